/* rtl/gtcs_pkg.sv */
// Package for the graph three-coloring search block.
// Shared constants, command/status codes, FSM state and control structs.
`timescale 1ns / 1ps
package gtcs_pkg;
  localparam int NV = 32;
  localparam logic [1:0] NO_COLOR = 2'd3;

  localparam logic [1:0] CMD_EDGE  = 2'd0;
  localparam logic [1:0] CMD_COLOR = 2'd1;
  localparam logic [1:0] CMD_SOLVE = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ENTRY   = 3'd1;
  localparam logic [2:0] ST_NOCOLOR = 3'd2;
  localparam logic [2:0] ST_CLASH   = 3'd3;
  localparam logic [2:0] ST_BAD     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PICK, S_ASSIGN, S_BACK, S_EMIT, S_CLEAR, S_RESULT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // apply edge / pre-color item
    logic chk_start;  // reset check scan
    logic chk_step;   // scan one vertex for clash
    logic pick_start; // reset pick scan
    logic pick_step;  // scan one vertex for pick
    logic assign_v;   // color the picked vertex and push
    logic back_step;  // retry top level with next color, or pop it
    logic emit_start;
    logic emit_step;
    logic clear;      // wipe stores
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic chk_done;
    logic clash;
    logic pick_done;
    logic pick_none;   // all colored
    logic pick_dead;   // picked vertex has no free color
    logic back_ok;     // popped level found another color
    logic depth_zero;
    logic emit_last;
  } stat_t;
endpackage

/* rtl/gtcs_datapath.sv */
// Datapath: adjacency matrix, color store, search stacks and scan counters.
// Depends on gtcs_pkg.
`timescale 1ns / 1ps
module gtcs_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  gtcs_pkg::cmd_t     cmd,
  output gtcs_pkg::stat_t    stat,
  input  logic [5:0]         n,
  input  logic [5:0]         vertex_a,
  input  logic [5:0]         vertex_b,
  input  logic [1:0]         fixed_color,
  input  logic               is_edge,
  output logic [5:0]         emit_vertex,
  output logic [1:0]         emit_color
);
  logic [31:0] adj_r [32];
  logic [1:0]  col_r [32];
  logic [4:0]  vstk_r [32];
  logic [1:0]  cstk_r [32];
  logic [5:0]  depth_r, depth_nxt;
  logic [5:0]  scan_r, scan_nxt;
  logic [4:0]  best_r, best_nxt;
  logic [1:0]  bestf_r, bestf_nxt;
  logic        found_r, found_nxt;
  logic        clash_r, clash_nxt;
  logic        dead_r, dead_nxt;

  logic [31:0] live;
  logic [4:0]  sv;
  logic [2:0]  used;
  logic [1:0]  freec;
  logic [4:0]  pv;
  logic [1:0]  pc;
  logic [2:0]  pused;
  logic [1:0]  nfree;
  logic [4:0]  ai, bi;
  logic        clash_hit, pick_take, dead_hit;

  assign live = (n >= 6'd32) ? 32'hffff_ffff : ((32'd1 << n[4:0]) - 32'd1);
  assign sv = scan_r[4:0] - 5'd1;

  // used colors of one vertex: independent OR over neighbors
  function automatic logic [2:0] used_of(input logic [31:0] row, input logic [1:0] cs [32]);
    logic [2:0] u;
    u = 3'd0;
    for (int w = 0; w < 32; w++)
      if (row[w] && cs[w] != gtcs_pkg::NO_COLOR) u[cs[w]] = 1'b1;
    return u;
  endfunction

  assign used  = used_of(adj_r[sv] & live, col_r);
  assign freec = 2'(3 - (32'(used[0]) + 32'(used[1]) + 32'(used[2])));

  // backtrack: popped level
  assign pv    = vstk_r[depth_r[4:0] - 5'd1];
  assign pc    = cstk_r[depth_r[4:0] - 5'd1];
  always_comb begin
    logic [31:0] row;
    row = adj_r[pv] & live;
    pused = 3'd0;
    for (int w = 0; w < 32; w++)
      if (row[w] && 5'(w) != pv && col_r[w] != gtcs_pkg::NO_COLOR) pused[col_r[w]] = 1'b1;
    nfree = gtcs_pkg::NO_COLOR;
    if (pc < 2'd2 && !pused[pc + 2'd1]) nfree = pc + 2'd1;
    else if (pc < 2'd1 && !pused[2]) nfree = 2'd2;
  end

  // first free color of the picked vertex
  logic [2:0] bused;
  logic [1:0] bfirst;
  assign bused  = used_of(adj_r[best_r] & live, col_r);
  assign bfirst = !bused[0] ? 2'd0 : (!bused[1] ? 2'd1 : 2'd2);

  assign ai = vertex_a[4:0] - 5'd1;
  assign bi = vertex_b[4:0] - 5'd1;

  // scan outcome including the vertex under the scan pointer
  assign clash_hit = clash_r || (col_r[sv] != gtcs_pkg::NO_COLOR && used[col_r[sv]]);
  assign pick_take = col_r[sv] == gtcs_pkg::NO_COLOR && (!found_r || freec < bestf_r);
  assign dead_hit  = dead_r || (pick_take && freec == 2'd0);

  // scan counters; a start wins over a step in the same cycle
  always_comb begin
    scan_nxt = scan_r; best_nxt = best_r; bestf_nxt = bestf_r;
    found_nxt = found_r; clash_nxt = clash_r; dead_nxt = dead_r;
    depth_nxt = depth_r;
    if (cmd.chk_step) begin
      clash_nxt = clash_hit;
      scan_nxt = scan_r + 6'd1;
    end
    if (cmd.pick_step) begin
      if (pick_take) begin
        found_nxt = 1'b1; best_nxt = sv; bestf_nxt = freec;
      end
      dead_nxt = dead_hit;
      scan_nxt = scan_r + 6'd1;
    end
    if (cmd.emit_step) scan_nxt = scan_r + 6'd1;
    if (cmd.chk_start || cmd.pick_start || cmd.emit_start) begin
      scan_nxt = 6'd1; found_nxt = 1'b0; clash_nxt = 1'b0; dead_nxt = 1'b0;
      bestf_nxt = 2'd3;
    end
    if (cmd.assign_v) depth_nxt = depth_r + 6'd1;
    if (cmd.back_step && nfree == gtcs_pkg::NO_COLOR) depth_nxt = depth_r - 6'd1;
    if (cmd.clear) depth_nxt = 6'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= 6'd0; scan_r <= 6'd1; found_r <= 1'b0;
      clash_r <= 1'b0; dead_r <= 1'b0; bestf_r <= 2'd3; best_r <= 5'd0;
    end else begin
      depth_r <= depth_nxt; scan_r <= scan_nxt; found_r <= found_nxt;
      clash_r <= clash_nxt; dead_r <= dead_nxt; bestf_r <= bestf_nxt; best_r <= best_nxt;
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 32; i++) begin
        adj_r[i] <= 32'd0;
        col_r[i] <= gtcs_pkg::NO_COLOR;
      end
    end else begin
      if (cmd.load) begin
        if (is_edge) begin
          adj_r[ai][bi] <= 1'b1;
          adj_r[bi][ai] <= 1'b1;
        end else begin
          col_r[ai] <= fixed_color;
        end
      end
      if (cmd.assign_v) col_r[best_r] <= bfirst;
      if (cmd.back_step) col_r[pv] <= nfree;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.assign_v) begin
      vstk_r[depth_r[4:0]] <= best_r;
      cstk_r[depth_r[4:0]] <= bfirst;
    end
    if (cmd.back_step && nfree != gtcs_pkg::NO_COLOR) cstk_r[depth_r[4:0] - 5'd1] <= nfree;
  end

  assign stat.chk_done   = (scan_r >= n);
  assign stat.clash      = clash_hit;
  assign stat.pick_done  = (scan_r >= n) || dead_hit;
  assign stat.pick_none  = !(found_r || pick_take);
  assign stat.pick_dead  = dead_hit;
  assign stat.back_ok    = (nfree != gtcs_pkg::NO_COLOR);
  assign stat.depth_zero = (depth_r == 6'd0);
  assign stat.emit_last  = (scan_r >= n);
  assign emit_vertex = scan_r;
  assign emit_color  = col_r[sv];
endmodule

/* rtl/gtcs_ctrl.sv */
// Controller FSM: sequences load, clash check, search, emit, clear and result.
// Depends on gtcs_pkg.
`timescale 1ns / 1ps
module gtcs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic [1:0]       in_cmd,
  input  logic             in_good,
  input  logic             out_free,
  input  gtcs_pkg::stat_t  stat,
  output gtcs_pkg::cmd_t   cmd,
  output logic             idle,
  output logic             emit_en,
  output logic             res_en,
  output logic [2:0]       res_status
);
  gtcs_pkg::state_t state_r, state_nxt;
  logic [2:0] st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtcs_pkg::S_IDLE; st_r <= gtcs_pkg::ST_OK;
    end else begin
      state_r <= state_nxt; st_r <= st_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r; st_nxt = st_r;
    unique case (state_r)
      gtcs_pkg::S_IDLE: begin
        if (in_fire && in_cmd == gtcs_pkg::CMD_SOLVE) state_nxt = gtcs_pkg::S_CHECK;
      end
      gtcs_pkg::S_CHECK: begin
        if (stat.chk_done) begin
          if (stat.clash) begin
            st_nxt = gtcs_pkg::ST_CLASH; state_nxt = gtcs_pkg::S_CLEAR;
          end else state_nxt = gtcs_pkg::S_PICK;
        end
      end
      gtcs_pkg::S_PICK: begin
        if (stat.pick_done) begin
          if (stat.pick_none) state_nxt = gtcs_pkg::S_EMIT;
          else if (stat.pick_dead) state_nxt = gtcs_pkg::S_BACK;
          else state_nxt = gtcs_pkg::S_ASSIGN;
        end
      end
      gtcs_pkg::S_ASSIGN: state_nxt = gtcs_pkg::S_PICK;
      gtcs_pkg::S_BACK: begin
        if (stat.depth_zero) begin
          st_nxt = gtcs_pkg::ST_NOCOLOR; state_nxt = gtcs_pkg::S_CLEAR;
        end else if (stat.back_ok) state_nxt = gtcs_pkg::S_PICK;
      end
      gtcs_pkg::S_EMIT: begin
        if (out_free && stat.emit_last) begin
          st_nxt = gtcs_pkg::ST_ENTRY; state_nxt = gtcs_pkg::S_CLEAR;
        end
      end
      gtcs_pkg::S_CLEAR: begin
        state_nxt = (st_r == gtcs_pkg::ST_ENTRY) ? gtcs_pkg::S_IDLE : gtcs_pkg::S_RESULT;
      end
      gtcs_pkg::S_RESULT: if (out_free) state_nxt = gtcs_pkg::S_IDLE;
      default: state_nxt = gtcs_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0; idle = 1'b0; emit_en = 1'b0; res_en = 1'b0;
    res_status = st_r;
    unique case (state_r)
      gtcs_pkg::S_IDLE: begin
        idle = 1'b1;
        cmd.load = in_fire && in_good && in_cmd != gtcs_pkg::CMD_SOLVE;
        cmd.chk_start = 1'b1;
      end
      gtcs_pkg::S_CHECK: begin
        cmd.chk_step = 1'b1;
        cmd.pick_start = stat.chk_done;
      end
      gtcs_pkg::S_PICK: begin
        cmd.pick_step = 1'b1;
        cmd.emit_start = stat.pick_done && stat.pick_none;
      end
      gtcs_pkg::S_ASSIGN: begin
        cmd.assign_v = 1'b1; cmd.pick_start = 1'b1;
      end
      gtcs_pkg::S_BACK: begin
        cmd.back_step = !stat.depth_zero;
        cmd.pick_start = 1'b1;
      end
      gtcs_pkg::S_EMIT: begin
        emit_en = out_free;
        cmd.emit_step = out_free;
      end
      gtcs_pkg::S_CLEAR: cmd.clear = 1'b1;
      gtcs_pkg::S_RESULT: res_en = out_free;
      default: ;
    endcase
  end
endmodule

/* rtl/graph_three_coloring_search_top.sv */
// Graph three-coloring search: edge/pre-color items load one per cycle while idle
// with the output free and give their result from the output register in the
// next cycle. A solve item holds off input: a check scan over n vertices, then per
// level a pick scan and an assign, backtrack pops, then n entries one per cycle
// while the output is free and a clear, or a clear and one result. Synchronous
// active-low reset clears the stores, marks all vertices uncolored, sets n_r to 32.
`timescale 1ns / 1ps
module graph_three_coloring_search_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cmd[1:0], vertex_a[7:2], vertex_b[13:8], fixed_color[15:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[2:0], out_vertex[8:3], out_color[10:9], zero pad
  output logic        out_tlast
);
  logic [5:0] n_r;
  logic [1:0] cmd_in;
  logic [5:0] va, vb;
  logic [1:0] fc;
  logic good, fire, out_free, idle, emit_en, res_en;
  logic [2:0] res_status;
  logic [5:0] ev;
  logic [1:0] ec;
  gtcs_pkg::cmd_t  cmd;
  gtcs_pkg::stat_t stat;
  logic [10:0] od_r;
  logic ov_r, ol_r;

  assign cmd_in = in_tdata[1:0];
  assign va = in_tdata[7:2];
  assign vb = in_tdata[13:8];
  assign fc = in_tdata[15:14];

  // hold count register; ignore out-of-range writes
  always_ff @(posedge clk) begin
    if (!rst_n) n_r <= 6'(gtcs_pkg::NV);
    else if (cfg_we && cfg_wdata >= 6'd1 && cfg_wdata <= 6'(gtcs_pkg::NV)) n_r <= cfg_wdata;
  end

  always_comb begin
    unique case (cmd_in)
      gtcs_pkg::CMD_EDGE: good = va >= 6'd1 && va <= n_r && vb >= 6'd1 && vb <= n_r && va != vb;
      gtcs_pkg::CMD_COLOR: good = va >= 6'd1 && va <= n_r && fc != gtcs_pkg::NO_COLOR;
      gtcs_pkg::CMD_SOLVE: good = 1'b1;
      default: good = 1'b0;
    endcase
  end

  assign out_free = !ov_r || out_tready;
  assign in_tready = idle && out_free;
  assign fire = in_tvalid && in_tready;

  gtcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(fire), .in_cmd(cmd_in), .in_good(good),
    .out_free(out_free), .stat(stat), .cmd(cmd), .idle(idle), .emit_en(emit_en),
    .res_en(res_en), .res_status(res_status)
  );

  gtcs_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .n(n_r),
    .vertex_a(va), .vertex_b(vb), .fixed_color(fc),
    .is_edge(cmd_in == gtcs_pkg::CMD_EDGE), .emit_vertex(ev), .emit_color(ec)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (out_free) ov_r <= (fire && cmd_in != gtcs_pkg::CMD_SOLVE) || emit_en || res_en;
  end
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (emit_en) begin
        od_r <= {ec, ev, gtcs_pkg::ST_ENTRY}; ol_r <= stat.emit_last;
      end else if (res_en) begin
        od_r <= {8'd0, res_status}; ol_r <= 1'b1;
      end else begin
        od_r <= {8'd0, good ? gtcs_pkg::ST_OK : gtcs_pkg::ST_BAD}; ol_r <= 1'b1;
      end
    end
  end
  assign out_tvalid = ov_r;
  assign out_tdata = {5'd0, od_r};
  assign out_tlast = ol_r;
endmodule

/* rtl/gtcs_checker.sv */
// Port checker for the graph three-coloring search top level, with bind.
// Depends on gtcs_pkg and the top-level ports.
`timescale 1ns / 1ps
module gtcs_checker (
  input logic clk, input logic rst_n,
  input logic out_tvalid, input logic out_tready,
  input logic [15:0] out_tdata, input logic out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output not held");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:11] == 5'd0) else $error("pad bits set");
  a_nonentry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != gtcs_pkg::ST_ENTRY |-> out_tdata[10:3] == 8'd0 && out_tlast)
    else $error("bad non-entry result");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= gtcs_pkg::ST_BAD) else $error("status out of range");
  a_entry_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == gtcs_pkg::ST_ENTRY |->
      out_tdata[8:3] != 6'd0 && out_tdata[10:9] != gtcs_pkg::NO_COLOR)
    else $error("bad entry");
endmodule

bind graph_three_coloring_search_top gtcs_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast)
);
